// ===== src/point_in_triangle_test_macros.svh =====
// Assertion helpers for the point-in-triangle pipeline
`ifndef POINT_IN_TRIANGLE_TEST_MACROS_SVH
`define POINT_IN_TRIANGLE_TEST_MACROS_SVH

`ifndef SYNTHESIS
`define PTT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("point_in_triangle_test: assertion failed");
`define PTT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("point_in_triangle_test: assertion failed");
`else
`define PTT_ASSERT(lbl, prop)
`define PTT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== src/pit_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pit_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 16;
  localparam int unsigned N_COORDS        = 12;
  localparam int unsigned N_DOTS          = 5;
  localparam int unsigned N_PRODS         = 6;
  localparam int unsigned N_STAGES        = 7;
  localparam int unsigned OUT_TDATA_W     = 8;

  typedef struct packed {
    logic dif;
    logic prd;
    logic dot;
    logic part;
    logic full;
    logic cmb;
    logic res;
  } pit_ld_t;

endpackage

`default_nettype wire

// ===== src/point_in_triangle_test.sv =====
`timescale 1ns / 1ps
`default_nettype none

// An input transfer is registered through the stages dif, prd, dot, part, full, cmb
// and res in that order; m_axis_tvalid_o is the valid bit of the res stage.
// Throughput: one item per cycle; a stalled output holds only the stages behind it.
// The depth is set by the dot products and the split DW x DW products.
// Reset (rst_ni low, asynchronous) empties every stage; no result is pending after it.

`include "point_in_triangle_test_macros.svh"

module point_in_triangle_test
  import pit_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          s_axis_tvalid_i,
  output logic                                          s_axis_tready_o,
  // point_x, point_y, point_z, vert_a_x .. vert_a_z, vert_b_x .. vert_b_z,
  // vert_c_x .. vert_c_z, each COORD_WIDTH bits
  input  logic [((N_COORDS*COORD_WIDTH+7)/8)*8-1:0]     s_axis_tdata_i,
  output logic                                          m_axis_tvalid_o,
  input  logic                                          m_axis_tready_i,
  // inside_res
  output logic [OUT_TDATA_W-1:0]                        m_axis_tdata_o,
  // degenerate
  output logic                                          m_axis_tuser_o
);

  localparam int unsigned DW = 2 * COORD_WIDTH + 4;
  localparam int unsigned TW = ((N_COORDS * COORD_WIDTH + 7) / 8) * 8;

  logic [N_STAGES-1:0] vld_q, vld_d;
  logic [N_STAGES-1:0] rdy;
  logic [N_STAGES-1:0] ld;
  pit_ld_t             ld_s;

  logic signed [DW-1:0]   dots [N_DOTS];
  logic signed [DW-1:0]   opa  [N_PRODS];
  logic signed [DW-1:0]   opb  [N_PRODS];
  logic signed [2*DW-1:0] prod [N_PRODS];
  logic                   in_tri, degen;

  always_comb begin
    rdy[N_STAGES-1] = !vld_q[N_STAGES-1] || m_axis_tready_i;
    for (int k = N_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    ld[0]    = s_axis_tvalid_i && rdy[0];
    vld_d[0] = rdy[0] ? s_axis_tvalid_i : vld_q[0];
    for (int k = 1; k < N_STAGES; k++) begin
      ld[k]    = vld_q[k-1] && rdy[k];
      vld_d[k] = rdy[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign ld_s = '{dif: ld[0], prd: ld[1], dot: ld[2], part: ld[3],
                  full: ld[4], cmb: ld[5], res: ld[6]};

  pit_dot #(
    .CW (COORD_WIDTH),
    .DW (DW),
    .TW (TW)
  ) u_dot (
    .clk_i    (clk_i),
    .ld_i     (ld_s),
    .coords_i (s_axis_tdata_i),
    .dots_o   (dots)
  );

  // dots: d00, d01, d02, d11, d12
  assign opa[0] = dots[0];  assign opb[0] = dots[3];
  assign opa[1] = dots[1];  assign opb[1] = dots[1];
  assign opa[2] = dots[3];  assign opb[2] = dots[2];
  assign opa[3] = dots[1];  assign opb[3] = dots[4];
  assign opa[4] = dots[0];  assign opb[4] = dots[4];
  assign opa[5] = dots[1];  assign opb[5] = dots[2];

  for (genvar g = 0; g < N_PRODS; g++) begin : g_mul
    pit_wmul #(
      .DW (DW)
    ) u_wmul (
      .clk_i (clk_i),
      .ld_i  (ld_s),
      .a_i   (opa[g]),
      .b_i   (opb[g]),
      .p_o   (prod[g])
    );
  end

  pit_decide #(
    .DW (DW)
  ) u_decide (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ld_i      (ld_s),
    .cmb_vld_i (vld_q[N_STAGES-2]),
    .res_vld_i (vld_q[N_STAGES-1]),
    .prod_i    (prod),
    .inside_o  (in_tri),
    .degen_o   (degen)
  );

  assign s_axis_tready_o = rdy[0];
  assign m_axis_tvalid_o = vld_q[N_STAGES-1];
  assign m_axis_tdata_o  = {{(OUT_TDATA_W-1){1'b0}}, in_tri};
  assign m_axis_tuser_o  = degen;

  `PTT_ASSERT(accept_when_empty_a, vld_q[0] || s_axis_tready_o)
  `PTT_ASSERT_NEXT(drain_to_out_a, vld_q[N_STAGES-2] && !vld_q[N_STAGES-1], vld_q[N_STAGES-1])

endmodule

`default_nettype wire

// ===== src/pit_dot.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pit_dot
  import pit_pkg::*;
#(
  parameter int unsigned CW = COORD_WIDTH_DEF,
  parameter int unsigned DW = 2 * CW + 4,
  parameter int unsigned TW = ((N_COORDS * CW + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  pit_ld_t              ld_i,
  input  logic [TW-1:0]        coords_i,
  output logic signed [DW-1:0] dots_o [N_DOTS]
);

  localparam int unsigned EW = CW + 1;
  localparam int unsigned PW = 2 * CW + 2;

  logic signed [CW-1:0] pt [3];
  logic signed [CW-1:0] va [3];
  logic signed [CW-1:0] vb [3];
  logic signed [CW-1:0] vc [3];

  logic signed [EW-1:0] e0_q [3];
  logic signed [EW-1:0] e1_q [3];
  logic signed [EW-1:0] w_q  [3];
  logic signed [PW-1:0] prd_q [N_DOTS][3];
  logic signed [DW-1:0] dot_q [N_DOTS];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pt[i] = coords_i[i*CW +: CW];
      va[i] = coords_i[(3+i)*CW +: CW];
      vb[i] = coords_i[(6+i)*CW +: CW];
      vc[i] = coords_i[(9+i)*CW +: CW];
    end
  end

  // edge vectors and offset from vertex A
  always_ff @(posedge clk_i) begin
    if (ld_i.dif) begin
      for (int i = 0; i < 3; i++) begin
        e0_q[i] <= EW'(vc[i]) - EW'(va[i]);
        e1_q[i] <= EW'(vb[i]) - EW'(va[i]);
        w_q[i]  <= EW'(pt[i]) - EW'(va[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.prd) begin
      for (int i = 0; i < 3; i++) begin
        prd_q[0][i] <= PW'(e0_q[i]) * PW'(e0_q[i]);
        prd_q[1][i] <= PW'(e0_q[i]) * PW'(e1_q[i]);
        prd_q[2][i] <= PW'(e0_q[i]) * PW'(w_q[i]);
        prd_q[3][i] <= PW'(e1_q[i]) * PW'(e1_q[i]);
        prd_q[4][i] <= PW'(e1_q[i]) * PW'(w_q[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.dot) begin
      for (int j = 0; j < N_DOTS; j++) begin
        dot_q[j] <= DW'(prd_q[j][0]) + DW'(prd_q[j][1]) + DW'(prd_q[j][2]);
      end
    end
  end

  assign dots_o = dot_q;

endmodule

`default_nettype wire

// ===== src/pit_wmul.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pit_wmul
  import pit_pkg::*;
#(
  parameter int unsigned DW = 2 * COORD_WIDTH_DEF + 4
) (
  input  logic                   clk_i,
  input  pit_ld_t                ld_i,
  input  logic signed [DW-1:0]   a_i,
  input  logic signed [DW-1:0]   b_i,
  output logic signed [2*DW-1:0] p_o
);

  localparam int unsigned H  = (DW + 1) / 2;
  localparam int unsigned HW = DW - H;
  localparam int unsigned PW = 2 * DW;

  logic signed [HW-1:0] a_hi, b_hi;
  logic signed [H:0]    a_lo, b_lo;

  logic signed [2*H+1:0]  ll_q;
  logic signed [HW+H:0]   hl_q;
  logic signed [HW+H:0]   lh_q;
  logic signed [2*HW-1:0] hh_q;
  logic signed [PW-1:0]   p_q;

  // split into signed high and unsigned low halves
  assign a_hi = a_i[DW-1:H];
  assign b_hi = b_i[DW-1:H];
  assign a_lo = {1'b0, a_i[H-1:0]};
  assign b_lo = {1'b0, b_i[H-1:0]};

  always_ff @(posedge clk_i) begin
    if (ld_i.part) begin
      ll_q <= (2*H+2)'(a_lo) * (2*H+2)'(b_lo);
      hl_q <= (HW+H+1)'(a_hi) * (HW+H+1)'(b_lo);
      lh_q <= (HW+H+1)'(a_lo) * (HW+H+1)'(b_hi);
      hh_q <= (2*HW)'(a_hi) * (2*HW)'(b_hi);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.full) begin
      p_q <= (PW'(hh_q) <<< (2*H)) + ((PW'(hl_q) + PW'(lh_q)) <<< H) + PW'(ll_q);
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// ===== src/pit_decide.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "point_in_triangle_test_macros.svh"

module pit_decide
  import pit_pkg::*;
#(
  parameter int unsigned DW = 2 * COORD_WIDTH_DEF + 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pit_ld_t                ld_i,
  input  logic                   cmb_vld_i,
  input  logic                   res_vld_i,
  input  logic signed [2*DW-1:0] prod_i [N_PRODS],
  output logic                   inside_o,
  output logic                   degen_o
);

  localparam int unsigned RW = 2 * DW + 3;

  logic signed [RW-1:0] den_q, nu_q, nv_q;
  logic signed [RW-1:0] slack;
  logic                 inside_q, degen_q;
  logic                 degen_d;

  always_ff @(posedge clk_i) begin
    if (ld_i.cmb) begin
      den_q <= RW'(prod_i[0]) - RW'(prod_i[1]);
      nu_q  <= RW'(prod_i[2]) - RW'(prod_i[3]);
      nv_q  <= RW'(prod_i[4]) - RW'(prod_i[5]);
    end
  end

  assign slack   = den_q - (nu_q + nv_q);
  assign degen_d = (den_q == '0) || den_q[RW-1];

  always_ff @(posedge clk_i) begin
    if (ld_i.res) begin
      degen_q  <= degen_d;
      inside_q <= !degen_d && !nu_q[RW-1] && !nv_q[RW-1] && !slack[RW-1];
    end
  end

  assign inside_o = inside_q;
  assign degen_o  = degen_q;

  `PTT_ASSERT(den_nonneg_a, !cmb_vld_i || !den_q[RW-1])
  `PTT_ASSERT(degen_not_inside_a, !res_vld_i || !(inside_q && degen_q))

endmodule

`default_nettype wire
